### design/rtc_register_file_emulator_assert.svh
// Assertion helpers for the RTC register file emulator.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef RTC_REGISTER_FILE_EMULATOR_ASSERT_SVH
`define RTC_REGISTER_FILE_EMULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RFE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rtcrfe_pkg.sv
package rtcrfe_pkg;

    // Default backing store depth
    localparam int NVRAM_DEPTH_DEF = 256;

    // Transaction actions
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_CHIP_TYPE = 1'b0;
    localparam logic CFG_NVRAM_EN  = 1'b1;

    // Chip layouts
    localparam logic CHIP_DS = 1'b0;
    localparam logic CHIP_MC = 1'b1;

    // Register addresses and masks
    localparam logic [7:0] DS_ADDR_MASK  = 8'h3F;
    localparam logic [7:0] DS_REG_HOUR   = 8'h02;
    localparam logic [7:0] DS_LAST_TIME  = 8'h06;
    localparam logic [7:0] DS_REG_CTRL   = 8'h07;
    localparam logic [7:0] DS_HOUR_MASK  = 8'h3F;
    localparam logic [7:0] DS_CTRL_MASK  = 8'h93;
    localparam logic [7:0] MC_LAST_TIME  = 8'h09;
    localparam logic [7:0] MC_REG_A      = 8'h0A;
    localparam logic [7:0] MC_REG_B      = 8'h0B;
    localparam logic [7:0] MC_REG_C      = 8'h0C;
    localparam logic [7:0] MC_REG_D      = 8'h0D;
    localparam logic [7:0] MC_FILTER_MAX = 8'h0D;
    localparam logic [7:0] MC_A_MASK     = 8'h7F;
    localparam logic [7:0] MC_B_SET      = 8'h02;
    localparam logic [7:0] MC_D_VALUE    = 8'h80;
    localparam logic [7:0] STORE_BLANK   = 8'hFF;

    // Last step of a clock update sweep
    localparam logic [2:0] UPD_LAST = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_WRES,
        ST_RD,
        ST_RRES
    } t_state;

    // Store access request from the sequencer
    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
    } t_store_req;

    // Binary to BCD: v + 6 * (v / 10), division by reciprocal (exact for every 8-bit input)
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [7:0]  six_q;
        prod  = 16'(v) * 16'd205;
        q     = prod[15:11] == 5'd0 ? prod[10:3] >> 8 : 8'(prod >> 11);
        six_q = 8'(q * 8'd6);
        return 8'(v + six_q);
    endfunction

    // BCD to binary: v - 6 * (v >> 4), modulo 256
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return 8'(v - 8'(hi * 8'd6));
    endfunction

    // MC146818 time register order for a clock update sweep
    function automatic logic [7:0] mc_upd_addr(input logic [2:0] k);
        logic [7:0] a;
        case (k)
            3'd0:    a = 8'h00;
            3'd1:    a = 8'h02;
            3'd2:    a = 8'h04;
            3'd3:    a = 8'h06;
            3'd4:    a = 8'h07;
            3'd5:    a = 8'h08;
            3'd6:    a = 8'h09;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

endpackage

### design/rtcrfe_store.sv
module rtcrfe_store
    import rtcrfe_pkg::*;
#(
    parameter int NVRAM_DEPTH = NVRAM_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output logic [7:0] o_rd_data
);

    localparam int AW = $clog2(NVRAM_DEPTH);

    logic [7:0]             r_mem [NVRAM_DEPTH];
    logic [NVRAM_DEPTH-1:0] r_valid;
    logic [7:0]             r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // Mark written entries; unwritten ones read as blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr[AW-1:0]] ?
                         r_mem[i_req.rd_addr[AW-1:0]] : STORE_BLANK;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/rtc_register_file_emulator.sv
// RTC register file emulator, DS1307 or MC146818 register layout.
// Bus read: the store is read in ST_RD and the result is loaded into the output register in ST_RRES.
// Bus write: ST_WR, then ST_WRES when a clock-set request is issued; dropped writes return to idle from ST_WR.
// Clock update: seven results issued one a cycle from the store read pipe while the output slot is free.
// One transaction at a time; a pending result that is not taken stalls the sequencer.
// Synchronous active-low reset; store entries read 0xFF until written (valid bits).
`include "rtc_register_file_emulator_assert.svh"

module rtc_register_file_emulator
    import rtcrfe_pkg::*;
#(
    parameter int NVRAM_DEPTH = NVRAM_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_reg_address,
    input  logic [7:0] i_write_data,
    input  logic [6:0] i_clk_year,
    input  logic [3:0] i_clk_month,
    input  logic [4:0] i_clk_day,
    input  logic [2:0] i_clk_weekday,
    input  logic [4:0] i_clk_hour,
    input  logic [5:0] i_clk_minute,
    input  logic [5:0] i_clk_second,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_out_address,
    output logic [7:0] o_out_data,
    output logic       o_last,
    output logic [7:0] o_set_year,
    output logic [7:0] o_set_month,
    output logic [7:0] o_set_day,
    output logic [7:0] o_set_hour,
    output logic [7:0] o_set_minute,
    output logic [7:0] o_set_second
);

    t_state r_state, n_state;

    logic       r_chip, r_nv_en;
    logic [7:0] r_addr, r_data;
    logic [2:0] r_k;
    logic       r_is_upd;
    logic [7:0] r_t_sec, r_t_min, r_t_hour, r_t_wday, r_t_day, r_t_mon, r_t_year;
    logic [7:0] r_a_sec, r_a_min, r_a_hour;
    logic       r_bcd;
    logic [7:0] r_prev_addr, r_prev_data;
    logic       r_prev_valid;

    logic       r_out_valid, r_kind, r_last;
    logic [7:0] r_out_addr, r_out_data;
    logic [7:0] r_set_year, r_set_month, r_set_day, r_set_hour, r_set_min, r_set_sec;

    logic       n_kind, n_last;
    logic [7:0] n_out_addr, n_out_data;

    t_store_req store_req;
    logic [7:0] rd_data;

    logic       accept, slot_free, load_out, k_inc;
    logic [7:0] cur_a, nxt_a, sget, tsel, other, enc, rd_value;
    logic       use_t;
    logic [7:0] wa, dsrc, dec;
    logic       drop, emits, store_case;

    // Backing store
    rtcrfe_store #(
        .NVRAM_DEPTH (NVRAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign accept    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // Read address of the current and the following sweep step
    always_comb begin
        if (r_is_upd) begin
            cur_a = (r_chip == CHIP_MC) ? mc_upd_addr(r_k) : {5'd0, r_k};
            nxt_a = (r_chip == CHIP_MC) ? mc_upd_addr(3'(r_k + 3'd1)) : {5'd0, 3'(r_k + 3'd1)};
        end else begin
            cur_a = (r_chip == CHIP_MC) ? r_addr : (r_addr & DS_ADDR_MASK);
            nxt_a = cur_a;
        end
    end

    // Decode a register read
    always_comb begin
        sget  = (!r_nv_en || !(32'(cur_a) < NVRAM_DEPTH)) ? STORE_BLANK : rd_data;
        use_t = 1'b0;
        tsel  = r_t_sec;
        other = sget;
        if (r_chip == CHIP_DS) begin
            case (cur_a)
                8'h00:   begin use_t = 1'b1; tsel = r_t_sec;  end
                8'h01:   begin use_t = 1'b1; tsel = r_t_min;  end
                8'h02:   begin use_t = 1'b1; tsel = r_t_hour; end
                8'h03:   begin use_t = 1'b1; tsel = r_t_wday; end
                8'h04:   begin use_t = 1'b1; tsel = r_t_day;  end
                8'h05:   begin use_t = 1'b1; tsel = r_t_mon;  end
                8'h06:   begin use_t = 1'b1; tsel = r_t_year; end
                DS_REG_CTRL: other = 8'h00;
                default: other = sget;
            endcase
        end else begin
            case (cur_a)
                8'h00:    begin use_t = 1'b1; tsel = r_t_sec;  end
                8'h01:    begin use_t = 1'b1; tsel = r_a_sec;  end
                8'h02:    begin use_t = 1'b1; tsel = r_t_min;  end
                8'h03:    begin use_t = 1'b1; tsel = r_a_min;  end
                8'h04:    begin use_t = 1'b1; tsel = r_t_hour; end
                8'h05:    begin use_t = 1'b1; tsel = r_a_hour; end
                8'h06:    begin use_t = 1'b1; tsel = r_t_wday; end
                8'h07:    begin use_t = 1'b1; tsel = r_t_day;  end
                8'h08:    begin use_t = 1'b1; tsel = r_t_mon;  end
                8'h09:    begin use_t = 1'b1; tsel = r_t_year; end
                MC_REG_A: other = sget & MC_A_MASK;
                MC_REG_B: other = sget | MC_B_SET;
                MC_REG_C: other = 8'h00;
                MC_REG_D: other = MC_D_VALUE;
                default:  other = sget;
            endcase
        end
        enc      = (r_chip == CHIP_DS || r_bcd) ? to_bcd(tsel) : tsel;
        rd_value = use_t ? enc : other;
    end

    // Decode a register write
    always_comb begin
        wa   = (r_chip == CHIP_MC) ? r_addr : (r_addr & DS_ADDR_MASK);
        drop = (r_chip == CHIP_MC) && r_prev_valid && (r_prev_addr == r_addr) &&
               (r_prev_data == r_data) && (r_addr <= MC_FILTER_MAX);
        dsrc = (r_chip == CHIP_DS && wa == DS_REG_HOUR) ? (r_data & DS_HOUR_MASK) : r_data;
        dec  = (r_chip == CHIP_DS || r_bcd) ? from_bcd(dsrc) : dsrc;
        if (r_chip == CHIP_DS) begin
            emits      = wa <= DS_LAST_TIME;
            store_case = wa >= DS_REG_CTRL;
        end else begin
            emits      = !drop && (wa <= MC_LAST_TIME);
            store_case = (wa == MC_REG_A) || (wa > MC_REG_D);
        end
    end

    // Sequencer: next state, store access and result load
    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        load_out          = 1'b0;
        k_inc             = 1'b0;
        store_req.rd_en   = 1'b0;
        store_req.rd_addr = cur_a;
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = wa;
        if (r_chip == CHIP_DS && wa == DS_REG_CTRL) begin
            store_req.wr_data = r_data & DS_CTRL_MASK;
        end else if (r_chip == CHIP_MC && wa == MC_REG_A) begin
            store_req.wr_data = r_data & MC_A_MASK;
        end else begin
            store_req.wr_data = r_data;
        end
        n_kind     = 1'b0;
        n_out_addr = cur_a;
        n_out_data = rd_value;
        n_last     = !r_is_upd || (r_k == UPD_LAST);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_action)
                        ACT_WRITE:  n_state = ST_WR;
                        ACT_READ:   n_state = ST_RD;
                        ACT_UPDATE: n_state = ST_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WR: begin
                store_req.wr_en = !drop && r_nv_en && store_case &&
                                  (32'(wa) < NVRAM_DEPTH);
                n_state = emits ? ST_WRES : ST_IDLE;
            end
            ST_WRES: begin
                n_kind     = 1'b1;
                n_out_addr = wa;
                n_out_data = r_data;
                n_last     = 1'b1;
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_RD: begin
                store_req.rd_en = 32'(cur_a) < NVRAM_DEPTH;
                n_state         = ST_RRES;
            end
            ST_RRES: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    if (r_is_upd && r_k != UPD_LAST) begin
                        // overlap the next sweep read with this result
                        k_inc             = 1'b1;
                        store_req.rd_addr = nxt_a;
                        store_req.rd_en   = 32'(nxt_a) < NVRAM_DEPTH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip  <= CHIP_DS;
            r_nv_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHIP_TYPE: r_chip  <= i_cfg_wdata;
                CFG_NVRAM_EN:  r_nv_en <= i_cfg_wdata;
                default:       r_chip  <= r_chip;
            endcase
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_reg_address;
            r_data <= i_write_data;
        end
    end

    // Sweep step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_is_upd <= 1'b0;
        end else if (accept) begin
            r_k      <= '0;
            r_is_upd <= (i_action == ACT_UPDATE);
        end else if (k_inc) begin
            r_k <= 3'(r_k + 3'd1);
        end
    end

    // Time, alarm and mode state: load on clock update, decode on bus write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_sec  <= 8'd0;
            r_t_min  <= 8'd0;
            r_t_hour <= 8'd0;
            r_t_wday <= 8'd0;
            r_t_day  <= 8'd1;
            r_t_mon  <= 8'd1;
            r_t_year <= 8'd0;
            r_a_sec  <= 8'd0;
            r_a_min  <= 8'd0;
            r_a_hour <= 8'd0;
            r_bcd    <= 1'b1;
        end else if (accept && i_action == ACT_UPDATE) begin
            r_t_year <= 8'(i_clk_year);
            r_t_mon  <= 8'(i_clk_month);
            r_t_day  <= 8'(i_clk_day);
            r_t_wday <= 8'(i_clk_weekday);
            r_t_hour <= 8'(i_clk_hour);
            r_t_min  <= 8'(i_clk_minute);
            r_t_sec  <= 8'(i_clk_second);
        end else if (r_state == ST_WR && !drop) begin
            if (r_chip == CHIP_DS) begin
                case (wa)
                    8'h00:   r_t_sec  <= dec;
                    8'h01:   r_t_min  <= dec;
                    8'h02:   r_t_hour <= dec;
                    8'h03:   r_t_wday <= dec;
                    8'h04:   r_t_day  <= dec;
                    8'h05:   r_t_mon  <= dec;
                    8'h06:   r_t_year <= dec;
                    default: r_bcd    <= r_bcd;
                endcase
            end else begin
                case (wa)
                    8'h00:    r_t_sec  <= dec;
                    8'h01:    r_a_sec  <= dec;
                    8'h02:    r_t_min  <= dec;
                    8'h03:    r_a_min  <= dec;
                    8'h04:    r_t_hour <= dec;
                    8'h05:    r_a_hour <= dec;
                    8'h06:    r_t_wday <= dec;
                    8'h07:    r_t_day  <= dec;
                    8'h08:    r_t_mon  <= dec;
                    8'h09:    r_t_year <= dec;
                    MC_REG_B: r_bcd    <= !r_data[2];
                    default:  r_bcd    <= r_bcd;
                endcase
            end
        end
    end

    // Remember the last write that was not filtered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_addr  <= 8'd0;
            r_prev_data  <= 8'd0;
            r_prev_valid <= 1'b0;
        end else if (r_state == ST_WR && !drop) begin
            r_prev_addr  <= r_addr;
            r_prev_data  <= r_data;
            r_prev_valid <= 1'b1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_kind      <= n_kind;
            r_out_addr  <= n_out_addr;
            r_out_data  <= n_out_data;
            r_last      <= n_last;
            r_set_year  <= n_kind ? r_t_year : 8'd0;
            r_set_month <= n_kind ? r_t_mon  : 8'd0;
            r_set_day   <= n_kind ? r_t_day  : 8'd0;
            r_set_hour  <= n_kind ? r_t_hour : 8'd0;
            r_set_min   <= n_kind ? r_t_min  : 8'd0;
            r_set_sec   <= n_kind ? r_t_sec  : 8'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_address = r_out_addr;
    assign o_out_data    = r_out_data;
    assign o_last        = r_last;
    assign o_set_year    = r_set_year;
    assign o_set_month   = r_set_month;
    assign o_set_day     = r_set_day;
    assign o_set_hour    = r_set_hour;
    assign o_set_minute  = r_set_min;
    assign o_set_second  = r_set_sec;

    // Checks on the sequencer
    `RFE_ASSERT_SAME(a_load_free, load_out, slot_free, "result loaded over a pending one")
    `RFE_ASSERT_SAME(a_wr_state, store_req.wr_en, r_state == ST_WR, "store write outside write step")
    `RFE_ASSERT_SAME(a_sweep_len, r_state == ST_RRES && r_is_upd, r_k <= UPD_LAST, "sweep overrun")
    `RFE_ASSERT_NEXT(a_last_idle, load_out && n_last, r_state == ST_IDLE, "last result not ending")

endmodule
